// ===== rtl/cfa_pkg.sv =====
// shared types and constants for the contiguous frame allocator
package cfa_pkg;

  localparam int ADDR_W         = 48;
  localparam int SIZE_W         = 32;
  localparam int LEN_W          = 11;
  localparam int FRAMES_W       = 11;
  localparam int NUM_FRAMES_DEF = 1024;
  localparam int FRAME_SIZE     = 4096;
  localparam int FRAME_SHIFT    = $clog2(FRAME_SIZE);
  localparam int CFG_IDX_W      = 1;

  // request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_FRAMES = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [SIZE_W-1:0] size_bytes;
    logic [ADDR_W-1:0] address;
  } in_item_t;

  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] block_address;
  } out_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   pool_base;
    logic [FRAMES_W-1:0] pool_frames;
  } cfg_t;

endpackage

// ===== rtl/cfa_ram.sv =====
// generic single write, single read ram with registered read data
module cfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/cfa_ctrl.sv =====
// request sequencer: frame map ram, first-fit scan, run mark and clear loop
module cfa_ctrl #(
  parameter int NUM_FRAMES = cfa_pkg::NUM_FRAMES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cfa_pkg::cfg_t      cfg,
  input  logic               req_valid,
  input  cfa_pkg::in_item_t  req,
  output logic               idle,
  output logic               res_valid,
  input  logic               res_ready,
  output cfa_pkg::out_item_t res
);
  import cfa_pkg::*;

  localparam int IW  = $clog2(NUM_FRAMES);
  localparam int CW  = $clog2(NUM_FRAMES + 1);
  localparam int WW  = LEN_W + 1;
  localparam int NW  = SIZE_W - FRAME_SHIFT + 1;
  localparam int QW  = ADDR_W - FRAME_SHIFT;
  localparam int PW  = (CW > FRAMES_W) ? CW : FRAMES_W;
  localparam int NCW = (NW > CW) ? NW : CW;
  localparam int QCW = (QW > CW) ? QW : CW;
  localparam int EW  = ((CW > LEN_W) ? CW : LEN_W) + 1;

  localparam logic [2:0] ST_CLR      = 3'd0;
  localparam logic [2:0] ST_IDLE     = 3'd1;
  localparam logic [2:0] ST_SCAN     = 3'd2;
  localparam logic [2:0] ST_FREE_RD  = 3'd3;
  localparam logic [2:0] ST_FREE_CHK = 3'd4;
  localparam logic [2:0] ST_MARK     = 3'd5;
  localparam logic [2:0] ST_DONE     = 3'd6;

  localparam logic [WW-1:0] WORD_FREE = {1'b0, LEN_W'(1)};
  localparam logic [CW-1:0] LAST_IDX  = CW'(NUM_FRAMES - 1);

  logic [2:0]        state_r, state_nxt;
  logic [CW-1:0]     wk_r, wk_nxt;
  logic              pend_r, pend_nxt;
  logic [CW-1:0]     iss_r, iss_nxt;
  logic [IW-1:0]     chk_r, chk_nxt;
  logic [CW-1:0]     run_r, run_nxt;
  logic [CW-1:0]     need_r, need_nxt;
  logic [CW-1:0]     wend_r, wend_nxt;
  logic [WW-1:0]     wdata_r, wdata_nxt;
  logic              res_ok_r, res_ok_nxt;
  logic [ADDR_W-1:0] res_addr_r, res_addr_nxt;

  logic              ram_we, ram_re;
  logic [IW-1:0]     ram_waddr, ram_raddr;
  logic [WW-1:0]     ram_wdata, ram_rdata;

  logic [CW-1:0]     nf;
  logic [NW-1:0]     need;
  logic              need_fit;
  logic [ADDR_W-1:0] off;
  logic              aligned;
  logic [QW-1:0]     fidx;
  logic              idx_ok;
  logic              rd_busy;
  logic [LEN_W-1:0]  rd_len;
  logic [CW-1:0]     run_inc;
  logic [CW-1:0]     chk_ext;
  logic [CW-1:0]     start;
  logic [ADDR_W-1:0] hit_addr;
  logic [EW-1:0]     end_sum;
  logic [CW-1:0]     end_clip;

  // frame map: busy bit over stored run length
  cfa_ram #(
    .WIDTH(WW),
    .DEPTH(NUM_FRAMES)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // frames in use, clipped to the map depth
  assign nf = (PW'(cfg.pool_frames) < PW'(NUM_FRAMES)) ? CW'(cfg.pool_frames)
                                                       : CW'(NUM_FRAMES);

  // request decode: frames needed, frame index of a free address
  assign need     = NW'(req.size_bytes >> FRAME_SHIFT)
                  + NW'(|req.size_bytes[FRAME_SHIFT-1:0]);
  assign need_fit = NCW'(need) <= NCW'(nf);
  assign off      = req.address - cfg.pool_base;
  assign aligned  = (off[FRAME_SHIFT-1:0] == '0);
  assign fidx     = off[ADDR_W-1:FRAME_SHIFT];
  assign idx_ok   = QCW'(fidx) < QCW'(nf);

  // scan step on the word read back
  assign rd_busy  = ram_rdata[LEN_W];
  assign rd_len   = ram_rdata[LEN_W-1:0];
  assign run_inc  = rd_busy ? '0 : run_r + CW'(1);
  assign chk_ext  = CW'(chk_r);
  assign start    = chk_ext + CW'(1) - need_r;
  assign hit_addr = cfg.pool_base + (ADDR_W'(start) << FRAME_SHIFT);

  // end of a free, clipped at the pool end
  assign end_sum  = EW'(wk_r) + EW'(rd_len);
  assign end_clip = (end_sum < EW'(nf)) ? CW'(end_sum) : nf;

  // ram port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wk_r[IW-1:0];
    ram_wdata = wdata_r;
    ram_re    = 1'b0;
    ram_raddr = iss_r[IW-1:0];
    case (state_r)
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_wdata = WORD_FREE;
      end
      ST_SCAN: begin
        ram_re = (iss_r < nf);
      end
      ST_FREE_RD: begin
        ram_re    = 1'b1;
        ram_raddr = wk_r[IW-1:0];
      end
      ST_MARK: begin
        ram_we = (wk_r < wend_r);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    wk_nxt       = wk_r;
    pend_nxt     = 1'b0;
    iss_nxt      = iss_r;
    chk_nxt      = chk_r;
    run_nxt      = run_r;
    need_nxt     = need_r;
    wend_nxt     = wend_r;
    wdata_nxt    = wdata_r;
    res_ok_nxt   = res_ok_r;
    res_addr_nxt = res_addr_r;
    case (state_r)
      ST_CLR: begin
        wk_nxt = wk_r + CW'(1);
        if (wk_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid) begin
          res_ok_nxt   = 1'b0;
          res_addr_nxt = '0;
          state_nxt    = ST_DONE;
          if (nf == '0) begin
            state_nxt = ST_DONE;
          end else if (req.kind == KIND_ALLOC) begin
            if (need == '0) begin
              res_ok_nxt   = 1'b1;
              res_addr_nxt = cfg.pool_base;
            end else if (need_fit) begin
              state_nxt = ST_SCAN;
              iss_nxt   = '0;
              run_nxt   = '0;
              need_nxt  = CW'(need);
              wdata_nxt = {1'b1, LEN_W'(need)};
            end
          end else begin
            if (aligned && idx_ok) begin
              state_nxt = ST_FREE_RD;
              wk_nxt    = CW'(fidx);
              wdata_nxt = WORD_FREE;
            end
          end
        end
      end
      ST_SCAN: begin
        // reads stream one frame a cycle, each checked in the cycle after its read
        pend_nxt = ram_re;
        chk_nxt  = iss_r[IW-1:0];
        if (ram_re) begin
          iss_nxt = iss_r + CW'(1);
        end
        if (pend_r) begin
          run_nxt = run_inc;
          if (run_inc == need_r) begin
            pend_nxt     = 1'b0;
            res_ok_nxt   = 1'b1;
            res_addr_nxt = hit_addr;
            wk_nxt       = start;
            wend_nxt     = chk_ext + CW'(1);
            state_nxt    = ST_MARK;
          end else if (chk_ext + CW'(1) == nf) begin
            pend_nxt  = 1'b0;
            state_nxt = ST_DONE;
          end
        end
      end
      ST_FREE_RD: begin
        state_nxt = ST_FREE_CHK;
      end
      ST_FREE_CHK: begin
        if (rd_busy) begin
          res_ok_nxt = 1'b1;
          wend_nxt   = end_clip;
          state_nxt  = ST_MARK;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_MARK: begin
        wk_nxt = wk_r + CW'(1);
        if (wk_r + CW'(1) >= wend_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      wk_r    <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wk_r    <= wk_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    iss_r      <= iss_nxt;
    chk_r      <= chk_nxt;
    run_r      <= run_nxt;
    need_r     <= need_nxt;
    wend_r     <= wend_nxt;
    wdata_r    <= wdata_nxt;
    res_ok_r   <= res_ok_nxt;
    res_addr_r <= res_addr_nxt;
  end

  assign idle      = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_DONE);
  assign res       = '{ok: res_ok_r, block_address: res_addr_r};

endmodule

// ===== rtl/contiguous_frame_allocator.sv =====
// An allocate scans the frame map for a free run, then marks the run it found;
// a free reads the frame word, then clears its run; zero size, empty pool or bad address go straight to the result.
// Throughput: one request at a time; the frame map scan reads one frame a cycle.
// Reset: synchronous active low; afterwards a clearing pass writes every frame
// free with run length one while in_stall stays high.
module contiguous_frame_allocator #(
  parameter int NUM_FRAMES = cfa_pkg::NUM_FRAMES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  cfa_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output cfa_pkg::out_item_t              out_data,
  input  logic                            cfg_we,
  input  logic [cfa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cfa_pkg::ADDR_W-1:0]      cfg_wdata
);
  import cfa_pkg::*;

  cfg_t      cfg_r, cfg_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;
  logic      ctrl_idle;
  logic      res_valid;
  logic      res_ready;
  out_item_t res;

  // configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_POOL_BASE:   cfg_nxt.pool_base   = cfg_wdata;
        CFG_POOL_FRAMES: cfg_nxt.pool_frames = cfg_wdata[FRAMES_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pool_base   <= '0;
      cfg_r.pool_frames <= FRAMES_W'(NUM_FRAMES_DEF);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // sequencer with frame map
  cfa_ctrl #(
    .NUM_FRAMES(NUM_FRAMES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .req_valid(in_valid && !in_stall),
    .req      (in_data),
    .idle     (ctrl_idle),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  assign in_stall = !ctrl_idle;

  // output register
  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/cfa_checker.sv =====
// port-level checks for the contiguous frame allocator, bound to the top level
module cfa_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input cfa_pkg::out_item_t  out_data
);
  import cfa_pkg::*;

  // reset always starts the clearing pass, so no request is taken right after
  assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("request taken right after reset");

  // each request stalls the input in the cycle after it is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken back to back");

  // a failed request never reports an address
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.ok |-> out_data.block_address == '0)
    else $error("address reported on failure");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind contiguous_frame_allocator cfa_checker u_cfa_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
